/* rtl/abg_pkg.sv */
package abg_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int PROD_W   = 2 * CHAN_W;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PROD_W-1:0] prod_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_MONO1 = 3'd0,
        MODE_MONO8 = 3'd1,
        MODE_RGB8  = 3'd2,
        MODE_BGR8  = 3'd3,
        MODE_CMYK8 = 3'd4
    } color_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_MODE = 3'd0,
        REG_BG_CHAN0   = 3'd1,
        REG_BG_CHAN1   = 3'd2,
        REG_BG_CHAN2   = 3'd3,
        REG_BG_CHAN3   = 3'd4
    } cfg_index_t;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_MONO8;
    localparam chan_t CHAN_FULL  = 8'hff;
    localparam chan_t CHAN_ZERO  = 8'h00;
    localparam logic [PROD_W:0] ROUND_HALF = 17'h00080;

endpackage

/* rtl/alpha_background_composite.sv */
// Alpha composite of a pixel stream over a fixed background color.
//
// Each request carries one pixel: four 8-bit channels, a mono bit and an
// 8-bit coverage alpha. Every channel that the color mode uses becomes
// div255((255 - a) * bg + a * pix); unused output channels are zero.
// In one-bit mono mode the mono bit is expanded to 0 or 255, blended with
// background channel 0, and out_bit is bit 7 of that blend.
//
// A request is taken on a rising edge with start high and busy low. Busy is
// always low: the pipeline takes a new pixel every cycle. The result of
// each pixel shows with done high once it has passed the four register
// stages: input capture, the channel multipliers, the sum with the
// divide-by-255 step, and the output mode select.
//
// The receiver cannot stall: each result stands for exactly one cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// should only happen while no pixel is in flight. Reset clears the pipeline
// valid bits and sets mode mono8 with a black background.
module alpha_background_composite (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [abg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mono_bit,
    input  abg_pkg::chan_t                 pix_chan0,
    input  abg_pkg::chan_t                 pix_chan1,
    input  abg_pkg::chan_t                 pix_chan2,
    input  abg_pkg::chan_t                 pix_chan3,
    input  abg_pkg::chan_t                 pix_alpha,
    output logic                          done,
    output logic                          out_bit,
    output abg_pkg::chan_t                 out_chan0,
    output abg_pkg::chan_t                 out_chan1,
    output abg_pkg::chan_t                 out_chan2,
    output abg_pkg::chan_t                 out_chan3
);
    import abg_pkg::*;

    // Configuration registers.
    logic [MODE_W-1:0] color_mode_reg;
    chan_t             bg_reg [NUM_CHAN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_RESET;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                bg_reg[i] <= CHAN_ZERO;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOR_MODE: color_mode_reg <= cfg_data[MODE_W-1:0];
                REG_BG_CHAN0:   bg_reg[0] <= cfg_data;
                REG_BG_CHAN1:   bg_reg[1] <= cfg_data;
                REG_BG_CHAN2:   bg_reg[2] <= cfg_data;
                REG_BG_CHAN3:   bg_reg[3] <= cfg_data;
                default:        ;
            endcase
            // Writes beyond the last register are dropped.
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits, one per stage, travel alongside the data.
    logic [3:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], accept};
        end
    end

    // Stage 0: capture the pixel. In one-bit mono mode channel 0 is
    // replaced by the expanded mono bit so the lanes need not know the mode.
    chan_t             pix_reg [NUM_CHAN];
    chan_t             alpha_reg;
    logic [MODE_W-1:0] mode_reg [3];

    always_ff @(posedge clk)
    begin
        if (color_mode_reg == MODE_MONO1)
        begin
            pix_reg[0] <= mono_bit ? CHAN_FULL : CHAN_ZERO;
        end
        else
        begin
            pix_reg[0] <= pix_chan0;
        end
        pix_reg[1]  <= pix_chan1;
        pix_reg[2]  <= pix_chan2;
        pix_reg[3]  <= pix_chan3;
        alpha_reg   <= pix_alpha;
        mode_reg[0] <= color_mode_reg;
        mode_reg[1] <= mode_reg[0];
        mode_reg[2] <= mode_reg[1];
    end

    // Stages 1 and 2: one blend lane per channel.
    chan_t blend [NUM_CHAN];

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        abg_lane u_lane (
            .clk     (clk),
            .bg      (bg_reg[c]),
            .pix     (pix_reg[c]),
            .alpha   (alpha_reg),
            .blended (blend[c])
        );
    end

    // Stage 3: zero the channels the mode does not use and register.
    logic  out_bit_next;
    chan_t out_chan_next [NUM_CHAN];

    always_comb
    begin
        out_bit_next = 1'b0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            out_chan_next[i] = CHAN_ZERO;
        end
        case (mode_reg[2])
            MODE_MONO1:
            begin
                out_bit_next     = blend[0][CHAN_W-1];
                out_chan_next[0] = blend[0];
            end
            MODE_MONO8:
            begin
                out_chan_next[0] = blend[0];
            end
            MODE_RGB8, MODE_BGR8:
            begin
                out_chan_next[0] = blend[0];
                out_chan_next[1] = blend[1];
                out_chan_next[2] = blend[2];
            end
            MODE_CMYK8:
            begin
                for (int i = 0; i < NUM_CHAN; i++)
                begin
                    out_chan_next[i] = blend[i];
                end
            end
            default: ;
        endcase
    end

    logic  out_bit_reg;
    chan_t out_chan_reg [NUM_CHAN];

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            out_chan_reg[i] <= out_chan_next[i];
        end
    end

    assign done      = valid_reg[3];
    assign out_bit   = out_bit_reg;
    assign out_chan0 = out_chan_reg[0];
    assign out_chan1 = out_chan_reg[1];
    assign out_chan2 = out_chan_reg[2];
    assign out_chan3 = out_chan_reg[3];

endmodule

/* rtl/abg_lane.sv */
module abg_lane (
    input  logic          clk,
    input  abg_pkg::chan_t bg,
    input  abg_pkg::chan_t pix,
    input  abg_pkg::chan_t alpha,
    output abg_pkg::chan_t blended
);
    import abg_pkg::*;

    // Two register stages: the two products, then the sum with the
    // divide-by-255 approximation (x + (x >> 8) + 0x80) >> 8.
    prod_t                bg_prod_reg;
    prod_t                pix_prod_reg;
    prod_t                sum_next;
    logic [PROD_W:0]      div_next;
    chan_t                blended_reg;

    always_ff @(posedge clk)
    begin
        bg_prod_reg  <= (CHAN_FULL - alpha) * bg;
        pix_prod_reg <= alpha * pix;
    end

    // The sum never exceeds 255 * 255, so it fits the product width.
    assign sum_next = bg_prod_reg + pix_prod_reg;
    assign div_next = {1'b0, sum_next} + {{(CHAN_W + 1){1'b0}}, sum_next[PROD_W-1:CHAN_W]}
                      + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        blended_reg <= div_next[PROD_W-1:CHAN_W];
    end

    assign blended = blended_reg;

endmodule

/* verif/abg_blend_checker.sv */
module abg_blend_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [abg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           mono_bit,
    input  abg_pkg::chan_t                 pix_chan0,
    input  abg_pkg::chan_t                 pix_chan1,
    input  abg_pkg::chan_t                 pix_chan2,
    input  abg_pkg::chan_t                 pix_chan3,
    input  abg_pkg::chan_t                 pix_alpha,
    input  logic                           done,
    input  logic                           out_bit,
    input  abg_pkg::chan_t                 out_chan0,
    input  abg_pkg::chan_t                 out_chan1,
    input  abg_pkg::chan_t                 out_chan2,
    input  abg_pkg::chan_t                 out_chan3,
    output int                             err_count,
    output int                             pending
);
    import abg_pkg::*;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_t;

    typedef struct packed {
        logic      mono;
        chan_vec_t chan;
    } pixel_result_t;

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0] mode_shadow;
    chan_vec_t         bg_shadow;

    pixel_result_t     blended_q[$];

    function automatic chan_t blend_chan(chan_t bg, chan_t pix, chan_t a);
        int unsigned av;
        int unsigned sum;
        begin
            av  = a;
            sum = (255 - av) * bg + av * pix;
            return chan_t'((sum + (sum >> 8) + 'h80) >> 8);
        end
    endfunction

    function automatic pixel_result_t composite_pixel(logic mbit, chan_vec_t pix, chan_t a);
        pixel_result_t r;
        chan_t         v;
        int            nch;
        begin
            r   = '0;
            nch = 0;
            case (mode_shadow)
                MODE_MONO1:
                begin
                    v         = blend_chan(bg_shadow[0], mbit ? CHAN_FULL : CHAN_ZERO, a);
                    r.mono    = v[CHAN_W-1];
                    r.chan[0] = v;
                end
                MODE_MONO8:            nch = 1;
                MODE_RGB8, MODE_BGR8:  nch = 3;
                MODE_CMYK8:            nch = NUM_CHAN;
                default:               nch = 0;
            endcase
            for (int i = 0; i < nch; i++)
                r.chan[i] = blend_chan(bg_shadow[i], pix[i], a);
            return r;
        end
    endfunction

    // Writes to indexes past the last register are dropped.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_shadow <= MODE_RESET;
            bg_shadow   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLOR_MODE: mode_shadow  <= cfg_data[MODE_W-1:0];
                REG_BG_CHAN0:   bg_shadow[0] <= cfg_data;
                REG_BG_CHAN1:   bg_shadow[1] <= cfg_data;
                REG_BG_CHAN2:   bg_shadow[2] <= cfg_data;
                REG_BG_CHAN3:   bg_shadow[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        chan_vec_t     got;
        int            fails;
        fails = 0;
        if (!rst_n)
        begin
            blended_q.delete();
            err_count <= 0;
            pending   <= 0;
        end
        else
        begin
            // Retire first: a result can never belong to a request taken at the same edge.
            if (done)
            begin
                if (blended_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    fails++;
                end
                else
                begin
                    want = blended_q.pop_front();
                    got  = {out_chan3, out_chan2, out_chan1, out_chan0};
                    if (out_bit !== want.mono)
                    begin
                        $display("%0t: out_bit expected %0b, actual %0b",
                                 $time, want.mono, out_bit);
                        fails++;
                    end
                    for (int i = 0; i < NUM_CHAN; i++)
                    begin
                        if (got[i] !== want.chan[i])
                        begin
                            $display("%0t: out_chan%0d expected %02h, actual %02h",
                                     $time, i, want.chan[i], got[i]);
                            fails++;
                        end
                    end
                end
            end
            if (start && !busy)
                blended_q.push_back(composite_pixel(mono_bit,
                    {pix_chan3, pix_chan2, pix_chan1, pix_chan0}, pix_alpha));
            err_count <= err_count + fails;
            pending   <= blended_q.size();
        end
    end

endmodule

/* verif/alpha_background_composite_tb.sv */
module alpha_background_composite_tb;

    import abg_pkg::*;

    // Pipeline depth of the block; drain waits this plus a little slack before any register write.
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic                  mono_bit;
    chan_t                 pix_chan0;
    chan_t                 pix_chan1;
    chan_t                 pix_chan2;
    chan_t                 pix_chan3;
    chan_t                 pix_alpha;
    logic                  done;
    logic                  out_bit;
    chan_t                 out_chan0;
    chan_t                 out_chan1;
    chan_t                 out_chan2;
    chan_t                 out_chan3;
    int                    err_count;
    int                    pending;
    int                    cycle_count;

    alpha_background_composite u_top (.*);

    // The checker sits beside the block, watching the register port, the
    // request handshake and the result strobe. It keeps its own copy of the
    // configuration, predicts every blended pixel and counts mismatches.
    abg_blend_checker u_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A channel value that lands on an extreme about a quarter of the time,
    // so alpha 0 and 255 and full or empty channels show up often.
    function automatic chan_t pick_chan();
        int r;
        begin
            r = $urandom_range(0, 7);
            if (r == 0)
                return CHAN_ZERO;
            else if (r == 1)
                return CHAN_FULL;
            return chan_t'($urandom_range(0, 255));
        end
    endfunction

    // Lower start and wait until every request has produced its result. The
    // extra cycles keep register writes well clear of the pipeline.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    // Program all five registers on back-to-back edges, then one write to an
    // index past the register file, which the block must ignore.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] mode_data,
                                input chan_t b0, input chan_t b1,
                                input chan_t b2, input chan_t b3);
        logic [CFG_DATA_W-1:0] vals[NUM_CHAN+1];
        vals[REG_COLOR_MODE] = mode_data;
        vals[REG_BG_CHAN0]   = b0;
        vals[REG_BG_CHAN1]   = b1;
        vals[REG_BG_CHAN2]   = b2;
        vals[REG_BG_CHAN3]   = b3;
        drain();
        for (int i = REG_COLOR_MODE; i <= REG_BG_CHAN3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_index <= CFG_IDX_W'(REG_BG_CHAN3 + 1 + $urandom_range(0, 2));
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Present one pixel and hold it until the block takes it. Start stays high
    // on return so that back-to-back requests need no extra assignment.
    task automatic send_pixel(input logic mbit, input chan_t p0, input chan_t p1,
                              input chan_t p2, input chan_t p3, input chan_t a);
        start     <= 1'b1;
        mono_bit  <= mbit;
        pix_chan0 <= p0;
        pix_chan1 <= p1;
        pix_chan2 <= p2;
        pix_chan3 <= p3;
        pix_alpha <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Idle cycles with start low; the data ports carry junk meanwhile.
    task automatic hold_off(input int cycles);
        start     <= 1'b0;
        mono_bit  <= 1'($urandom_range(0, 1));
        pix_chan0 <= chan_t'($urandom_range(0, 255));
        pix_chan1 <= chan_t'($urandom_range(0, 255));
        pix_chan2 <= chan_t'($urandom_range(0, 255));
        pix_chan3 <= chan_t'($urandom_range(0, 255));
        pix_alpha <= chan_t'($urandom_range(0, 255));
        repeat (cycles)
            @(posedge clk);
    endtask

    // A run of random pixels. Roughly one request in ten is preceded by a short
    // gap, unless the caller asks for an unbroken stream.
    task automatic send_random(input int count, input bit steady);
        for (int n = 0; n < count; n++)
        begin
            if (!steady && $urandom_range(0, 99) < 10)
                hold_off(1);
            send_pixel(1'($urandom_range(0, 1)), pick_chan(), pick_chan(),
                       pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    // Watchdog: a run that never drains ends here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [MODE_W-1:0] mode_pick;
        chan_t             bg_lo;
        chan_t             bg_hi;

        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        mono_bit  = 1'b0;
        pix_chan0 = '0;
        pix_chan1 = '0;
        pix_chan2 = '0;
        pix_chan3 = '0;
        pix_alpha = '0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset configuration is mono8 over a black background.
        send_pixel(1'b1, CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO, 8'h80);
        send_pixel(1'b0, 8'h5a, CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_FULL);

        // Directed sweep over every mode value, the three unused encodings
        // included. Odd modes go in with junk in the upper data bits to show
        // that only the low bits of the mode register count. Each mode sees
        // alpha 0, alpha 255 and a half blend, with full and empty channels.
        for (int m = 0; m < (1 << MODE_W); m++)
        begin
            bg_lo = m[0] ? CHAN_ZERO : CHAN_FULL;
            bg_hi = m[0] ? CHAN_FULL : CHAN_ZERO;
            program_regs(CFG_DATA_W'(m) | (m[0] ? 8'hf8 : 8'h00),
                         bg_lo, bg_hi, 8'h5a, 8'ha5);
            send_pixel(1'b1, CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_ZERO, CHAN_ZERO);
            send_pixel(1'b0, CHAN_ZERO, CHAN_FULL, CHAN_ZERO, CHAN_FULL, CHAN_FULL);
            send_pixel(1'b1, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h80);
        end

        // Random phases, each under a fresh setting. The first two use an
        // all-black and an all-white background, and one phase in the middle
        // runs without any gap between requests.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if ($urandom_range(0, 9) < 8)
                mode_pick = MODE_W'($urandom_range(MODE_MONO1, MODE_CMYK8));
            else
                mode_pick = MODE_W'($urandom_range(MODE_CMYK8 + 1, (1 << MODE_W) - 1));
            if (p == 0)
                program_regs(CFG_DATA_W'(MODE_CMYK8), CHAN_ZERO, CHAN_ZERO,
                             CHAN_ZERO, CHAN_ZERO);
            else if (p == 1)
                program_regs({5'($urandom_range(0, 31)), mode_pick}, CHAN_FULL,
                             CHAN_FULL, CHAN_FULL, CHAN_FULL);
            else
                program_regs({5'($urandom_range(0, 31)), mode_pick}, pick_chan(),
                             pick_chan(), pick_chan(), pick_chan());
            send_random(PHASE_ITEMS, p == RAND_PHASES / 2);
        end

        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
